### sv/vtp_pkg.sv
// Shared types and constants for the vector-to-polar pipeline.
// Holds the datapath widths, the arctangent table in degrees and the gain correction.
// No dependencies.
package vtp_pkg;

  localparam int XW        = 36;
  localparam int ZW        = 35;
  localparam int GUARD     = 16;
  localparam int ANG_FRAC  = 24;
  localparam int TABLE_LEN = 24;

  localparam logic [23:0] KINV = 24'd10188014;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360) <<< ANG_FRAC;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vtp_rot_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = ZW'(754974720);
      5'd1:    v = ZW'(445687602);
      5'd2:    v = ZW'(235489088);
      5'd3:    v = ZW'(119537938);
      5'd4:    v = ZW'(60000934);
      5'd5:    v = ZW'(30029717);
      5'd6:    v = ZW'(15018523);
      5'd7:    v = ZW'(7509720);
      5'd8:    v = ZW'(3754917);
      5'd9:    v = ZW'(1877466);
      5'd10:   v = ZW'(938734);
      5'd11:   v = ZW'(469367);
      5'd12:   v = ZW'(234684);
      5'd13:   v = ZW'(117342);
      5'd14:   v = ZW'(58671);
      5'd15:   v = ZW'(29335);
      5'd16:   v = ZW'(14668);
      5'd17:   v = ZW'(7334);
      5'd18:   v = ZW'(3667);
      5'd19:   v = ZW'(1833);
      5'd20:   v = ZW'(917);
      5'd21:   v = ZW'(458);
      5'd22:   v = ZW'(229);
      5'd23:   v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/vtp_front.sv
// Input stage: forms the difference vector, folds it into the right half plane
// and flags the zero vector. Depends on vtp_pkg.
module vtp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    start_x,
  input  logic signed [15:0]    start_y,
  input  logic signed [15:0]    end_x,
  input  logic signed [15:0]    end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output vtp_pkg::vtp_rot_t     out_data
);
  import vtp_pkg::*;

  logic                 en;
  logic                 valid_r;
  vtp_rot_t             data_r;
  vtp_rot_t             data_nxt;
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [16:0]   fx;
  logic signed [16:0]   fy;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    dx = 17'(end_x) - 17'(start_x);
    dy = 17'(end_y) - 17'(start_y);
    fx = dx[16] ? -dx : dx;
    fy = dx[16] ? -dy : dy;
    data_nxt.x    = XW'(fx) <<< GUARD;
    data_nxt.y    = XW'(fy) <<< GUARD;
    data_nxt.z    = dx[16] ? HALF_TURN : '0;
    data_nxt.zero = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### sv/vtp_rot.sv
// One registered micro-rotation of the vectoring CORDIC.
// Depends on vtp_pkg for the datapath record and the arctangent table.
module vtp_rot #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vtp_pkg::vtp_rot_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vtp_pkg::vtp_rot_t out_data
);
  import vtp_pkg::*;

  logic                 en;
  logic                 valid_r;
  vtp_rot_t             data_r;
  vtp_rot_t             data_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    xs  = in_data.x >>> STEP;
    ys  = in_data.y >>> STEP;
    ang = atan_deg(5'(STEP));
    data_nxt.zero = in_data.zero;
    if (!in_data.y[XW-1]) begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + ang;
    end else begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### sv/vtp_post.sv
// Output stages: gain correction as two partial products, angle wrap and rounding.
// Depends on vtp_pkg; the second register is the block's output register.
module vtp_post #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vtp_pkg::vtp_rot_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [17+FRACTION_BITS-1:0] out_magnitude,
  output logic [9+FRACTION_BITS-1:0]  out_direction,
  output logic                       out_zero
);
  import vtp_pkg::*;

  localparam int MW = 17 + FRACTION_BITS;
  localparam int DW = 9 + FRACTION_BITS;
  localparam int SW = 60;

  logic                 en_a;
  logic                 en_b;
  logic                 va_r;
  logic                 vb_r;

  logic [XW-2:0]        xu;
  logic [40:0]          pl_nxt;
  logic [41:0]          ph_nxt;
  logic signed [ZW-1:0] zw_nxt;

  logic [40:0]          pl_r;
  logic [41:0]          ph_r;
  logic signed [ZW-1:0] zw_r;
  logic                 zero_a_r;

  logic [SW-1:0]        msum;
  logic [ZW-1:0]        dsum;
  logic [DW:0]          dir_pre;
  logic [DW:0]          dir_fix;
  logic [MW-1:0]        mag_nxt;
  logic [DW-1:0]        dir_nxt;

  logic [MW-1:0]        mag_r;
  logic [DW-1:0]        dir_r;
  logic                 zero_r;

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    xu     = in_data.x[XW-1] ? '0 : in_data.x[XW-2:0];
    pl_nxt = 41'(xu[16:0]) * 41'(KINV);
    ph_nxt = 42'(xu[XW-2:17]) * 42'(KINV);
    zw_nxt = in_data.z[ZW-1] ? in_data.z + FULL_TURN : in_data.z;
  end

  always_comb begin
    msum    = (SW'(ph_r) << 17) + SW'(pl_r) + (SW'(1) << (39 - FRACTION_BITS));
    mag_nxt = msum[40-FRACTION_BITS +: MW];
    dsum    = ZW'(zw_r) + (ZW'(1) << (23 - FRACTION_BITS));
    dir_pre = dsum[24-FRACTION_BITS +: DW+1];
    dir_fix = (dir_pre >= ((DW+1)'(360) << FRACTION_BITS)) ?
              dir_pre - ((DW+1)'(360) << FRACTION_BITS) : dir_pre;
    dir_nxt = dir_fix[DW-1:0];
    if (zero_a_r) begin
      mag_nxt = '0;
      dir_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
    if (en_a && in_valid) begin
      pl_r     <= pl_nxt;
      ph_r     <= ph_nxt;
      zw_r     <= zw_nxt;
      zero_a_r <= in_data.zero;
    end
    if (en_b && va_r) begin
      mag_r  <= mag_nxt;
      dir_r  <= dir_nxt;
      zero_r <= zero_a_r;
    end
  end

  assign out_valid     = vb_r;
  assign out_magnitude = mag_r;
  assign out_direction = dir_r;
  assign out_zero      = zero_r;

endmodule

### sv/vector_to_polar_degrees.sv
// Top level of the pipelined vector-to-polar converter (magnitude and direction in degrees).
// Depends on vtp_pkg, vtp_front, vtp_rot and vtp_post.
//
// Channel  Ports       Contents
// in_      tvalid/rdy  start_x, start_y, end_x, end_y, 16-bit signed each
// out_     tvalid/rdy  magnitude, direction_deg in tdata; zero_vector in tuser
//
// A new request can be taken in every cycle unless a stall holds the pipeline; one result
// follows each request. The pipeline has one input stage, one register per micro-rotation
// and two output stages for the gain multiply.
// Each stage holds its item under a stall and accepts a new one once it empties.
// Reset clears only the valid bits.
module vector_to_polar_degrees #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // magnitude, then direction_deg, then zero padding to a whole byte
  output logic [((26+2*FRACTION_BITS+7)/8)*8-1:0] out_tdata,
  // zero_vector
  output logic [0:0]  out_tuser
);
  import vtp_pkg::*;

  localparam int N  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int MW = 17 + FRACTION_BITS;
  localparam int DW = 9 + FRACTION_BITS;
  localparam int TW = ((MW + DW + 7) / 8) * 8;

  vtp_rot_t      rot_data  [N+1];
  logic          rot_valid [N+1];
  logic          rot_ready [N+1];
  logic [MW-1:0] magnitude;
  logic [DW-1:0] direction_deg;
  logic          zero_vector;

  vtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_x   (in_tdata[15:0]),
    .start_y   (in_tdata[31:16]),
    .end_x     (in_tdata[47:32]),
    .end_y     (in_tdata[63:48]),
    .out_valid (rot_valid[0]),
    .out_ready (rot_ready[0]),
    .out_data  (rot_data[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_rot
    vtp_rot #(
      .STEP (k)
    ) u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rot_valid[k]),
      .in_ready  (rot_ready[k]),
      .in_data   (rot_data[k]),
      .out_valid (rot_valid[k+1]),
      .out_ready (rot_ready[k+1]),
      .out_data  (rot_data[k+1])
    );
  end

  vtp_post #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rot_valid[N]),
    .in_ready      (rot_ready[N]),
    .in_data       (rot_data[N]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_magnitude (magnitude),
    .out_direction (direction_deg),
    .out_zero      (zero_vector)
  );

  assign out_tdata = TW'({direction_deg, magnitude});
  assign out_tuser = zero_vector;

endmodule
